// File: rtl/core/c2sw_pkg.sv
// Shared types and constants for the Cartesian to spherical window unit.
`timescale 1ns / 1ps
package c2sw_pkg;

    typedef struct packed {
        logic signed [31:0] x_coord;
        logic signed [31:0] y_coord;
        logic signed [31:0] z_coord;
    } t_point;

    typedef struct packed {
        logic        [31:0] radius;
        logic        [15:0] azimuth;
        logic signed [15:0] elevation;
        logic        [2:0]  window_code;
    } t_result;

    localparam int SQRT_STEPS   = 32;
    localparam int CORDIC_ITERS = 20;
    localparam int CORDIC_PRE   = 3;
    localparam int CORDIC_LAT   = CORDIC_PRE + CORDIC_ITERS;
    localparam int CORDIC_W     = 36;
    localparam int ANGLE_W      = 24;

    localparam logic [21:0] ATAN_TAB [CORDIC_ITERS] = '{
        22'd2097152, 22'd1238021, 22'd654136, 22'd332050, 22'd166669,
        22'd83416,   22'd41718,   22'd20860,  22'd10430,  22'd5215,
        22'd2608,    22'd1304,    22'd652,    22'd326,    22'd163,
        22'd81,      22'd41,      22'd20,     22'd10,     22'd5
    };

    typedef logic [2:0] t_cfg_idx;
    localparam t_cfg_idx CFG_RADIUS_MIN    = 3'd0;
    localparam t_cfg_idx CFG_RADIUS_MAX    = 3'd1;
    localparam t_cfg_idx CFG_AZIMUTH_MIN   = 3'd2;
    localparam t_cfg_idx CFG_AZIMUTH_MAX   = 3'd3;
    localparam t_cfg_idx CFG_ELEVATION_MIN = 3'd4;
    localparam t_cfg_idx CFG_ELEVATION_MAX = 3'd5;

    typedef enum logic [2:0] {
        WIN_INSIDE  = 3'd0,
        WIN_RAD_LOW = 3'd1,
        WIN_RAD_HI  = 3'd2,
        WIN_AZ_LOW  = 3'd3,
        WIN_AZ_HI   = 3'd4,
        WIN_EL_LOW  = 3'd5,
        WIN_EL_HI   = 3'd6
    } t_win_code;

endpackage

// File: rtl/core/c2sw_delay.sv
// Clock-enabled shift register that keeps side data aligned with the pipeline.
`timescale 1ns / 1ps
module c2sw_delay #(
    parameter int W = 8,
    parameter int D = 4
) (
    input  logic         i_clk,
    input  logic         i_ce,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);
    logic [W-1:0] r_sh [D];

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_sh[0] <= i_d;
            for (int k = 1; k < D; k++) begin
                r_sh[k] <= r_sh[k-1];
            end
        end
    end

    assign o_q = r_sh[D-1];
endmodule

// File: rtl/core/c2sw_sqrt.sv
// Pipelined restoring integer square root, one result bit per stage.
`timescale 1ns / 1ps
module c2sw_sqrt (
    input  logic        i_clk,
    input  logic        i_ce,
    input  logic [63:0] i_val,
    output logic [31:0] o_root
);
    import c2sw_pkg::*;

    logic [63:0] w_rem [SQRT_STEPS+1];
    logic [63:0] w_res [SQRT_STEPS+1];

    assign w_rem[0] = i_val;
    assign w_res[0] = '0;

    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
        localparam logic [63:0] STEP_BIT = 64'd1 << (62 - 2 * k);
        logic [63:0] w_trial;
        logic [63:0] n_rem;
        logic [63:0] n_res;
        logic [63:0] r_res;

        always_comb begin
            w_trial = w_res[k] + STEP_BIT;
            if (w_rem[k] >= w_trial) begin
                n_rem = w_rem[k] - w_trial;
                n_res = (w_res[k] >> 1) + STEP_BIT;
            end else begin
                n_rem = w_rem[k];
                n_res = w_res[k] >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_res <= n_res;
            end
        end
        assign w_res[k+1] = r_res;

        if (k < SQRT_STEPS - 1) begin : g_rem
            logic [63:0] r_rem;
            always_ff @(posedge i_clk) begin
                if (i_ce) begin
                    r_rem <= n_rem;
                end
            end
            assign w_rem[k+1] = r_rem;
        end else begin : g_last
            assign w_rem[k+1] = n_rem;
        end
    end

    assign o_root = w_res[SQRT_STEPS][31:0];
endmodule

// File: rtl/core/c2sw_cordic.sv
// Pipelined vectoring CORDIC with input normalization, giving the angle of (u, v).
`timescale 1ns / 1ps
module c2sw_cordic (
    input  logic                              i_clk,
    input  logic                              i_ce,
    input  logic signed [32:0]                i_u,
    input  logic signed [32:0]                i_v,
    output logic signed [c2sw_pkg::ANGLE_W-1:0] o_angle
);
    import c2sw_pkg::*;

    function automatic logic [4:0] lz16(input logic [15:0] a);
        logic [4:0] n;
        n = 5'd16;
        for (int b = 0; b < 16; b++) begin
            if (a[b]) begin
                n = 5'(15 - b);
            end
        end
        return n;
    endfunction

    logic signed [32:0] n_vabs;
    logic        [31:0] n_m;
    logic signed [32:0] r_u1, r_v1, r_u2, r_v2;
    logic        [31:0] r_m1;
    logic        [4:0]  r_lz_hi, r_lz_lo;
    logic               r_hi_zero, r_zero2;
    logic        [5:0]  w_sh6;
    logic        [4:0]  w_sh;

    logic signed [CORDIC_W-1:0] w_u   [CORDIC_ITERS+1];
    logic signed [CORDIC_W-1:0] w_v   [CORDIC_ITERS+1];
    logic signed [ANGLE_W-1:0]  w_acc [CORDIC_ITERS+1];
    logic                       w_zero [CORDIC_ITERS+1];
    logic signed [CORDIC_W-1:0] r_u0, r_v0;
    logic                       r_zero0;

    always_comb begin
        n_vabs = i_v[32] ? -i_v : i_v;
        n_m    = (i_u > n_vabs) ? i_u[31:0] : n_vabs[31:0];
    end

    assign w_sh6 = r_hi_zero ? (6'd16 + 6'(r_lz_lo)) : 6'(r_lz_hi);
    assign w_sh  = w_sh6[4:0];

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_u1      <= i_u;
            r_v1      <= i_v;
            r_m1      <= n_m;
            r_u2      <= r_u1;
            r_v2      <= r_v1;
            r_lz_hi   <= lz16(r_m1[31:16]);
            r_lz_lo   <= lz16(r_m1[15:0]);
            r_hi_zero <= (r_m1[31:16] == 16'd0);
            r_zero2   <= (r_m1 == 32'd0);
            r_u0      <= CORDIC_W'(r_u2) <<< w_sh;
            r_v0      <= CORDIC_W'(r_v2) <<< w_sh;
            r_zero0   <= r_zero2;
        end
    end

    assign w_u[0]    = r_u0;
    assign w_v[0]    = r_v0;
    assign w_acc[0]  = '0;
    assign w_zero[0] = r_zero0;

    for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_iter
        logic signed [CORDIC_W-1:0] w_du, w_dv, n_u, n_v, r_u, r_v;
        logic signed [ANGLE_W-1:0]  w_t, n_acc, r_acc;
        logic                       r_zero;

        always_comb begin
            w_du = w_v[i] >>> i;
            w_dv = w_u[i] >>> i;
            w_t  = $signed(ANGLE_W'(ATAN_TAB[i]));
            if (w_v[i] > 0) begin
                n_u   = w_u[i] + w_du;
                n_v   = w_v[i] - w_dv;
                n_acc = w_acc[i] + w_t;
            end else begin
                n_u   = w_u[i] - w_du;
                n_v   = w_v[i] + w_dv;
                n_acc = w_acc[i] - w_t;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_u    <= n_u;
                r_v    <= n_v;
                r_acc  <= n_acc;
                r_zero <= w_zero[i];
            end
        end

        assign w_u[i+1]    = r_u;
        assign w_v[i+1]    = r_v;
        assign w_acc[i+1]  = r_acc;
        assign w_zero[i+1] = r_zero;
    end

    assign o_angle = w_zero[CORDIC_ITERS] ? '0 : w_acc[CORDIC_ITERS];
endmodule

// File: rtl/core/cartesian_to_spherical_window_unit.sv
// Throughput: one beat per cycle; a stalled output freezes the whole pipeline.
// The radius and the horizontal distance come from two 32-stage square root pipelines,
// the angles from two 23-stage CORDIC pipelines that follow them.
// Reset clears all valid bits and restores the window limits to their defaults.
`timescale 1ns / 1ps
module cartesian_to_spherical_window_unit (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  c2sw_pkg::t_point          i_in_data,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output c2sw_pkg::t_result         o_out_data,
    input  logic                      i_cfg_we,
    input  c2sw_pkg::t_cfg_idx        i_cfg_idx,
    input  logic [31:0]               i_cfg_data
);
    import c2sw_pkg::*;

    localparam int PIPE_DEPTH = 3 + SQRT_STEPS + CORDIC_LAT + 2;
    localparam int DA_W = 33 + 33 + 1 + 32;
    localparam int DB_W = 32 + 4;

    logic [31:0]        r_rad_min, r_rad_max;
    logic [16:0]        r_az_min, r_az_max;
    logic signed [15:0] r_el_min, r_el_max;

    logic [PIPE_DEPTH-1:0] r_vld;
    logic                  w_ce;

    t_point             r_s1;
    logic [31:0]        w_mx, w_my, w_mz;
    logic [63:0]        r_sx, r_sy, r_sz;
    logic signed [32:0] n_au, n_av, r_au, r_av;
    logic               r_base;
    logic signed [31:0] r_z2;
    logic [63:0]        r_rxy2, r_r2;

    logic [31:0]        w_rho, w_rad;
    logic [DA_W-1:0]    w_da;
    logic signed [32:0] w_d_au, w_d_av;
    logic               w_d_base;
    logic signed [31:0] w_d_z;
    logic [DB_W-1:0]    w_db;
    logic [31:0]        w_b_rad;
    logic               w_b_base, w_b_rho0, w_b_zneg, w_b_znz;

    logic signed [ANGLE_W-1:0] w_acc_az, w_acc_el;
    logic signed [25:0]        w_az_sum;
    logic signed [24:0]        w_el_sum, w_el_sh;
    logic [15:0]               n_az;
    logic signed [15:0]        n_el;
    logic [31:0]               r_p_rad;
    logic [15:0]               r_p_az;
    logic signed [15:0]        r_p_el;
    t_win_code                 n_code;
    t_result                   r_out;

    assign w_ce        = ~(r_vld[PIPE_DEPTH-1] & i_out_stall);
    assign o_in_stall  = ~w_ce;
    assign o_out_valid = r_vld[PIPE_DEPTH-1];
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rad_min <= 32'd0;
            r_rad_max <= 32'd6553600;
            r_az_min  <= 17'd0;
            r_az_max  <= 17'd16384;
            r_el_min  <= 16'sd0;
            r_el_max  <= 16'sd16384;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_RADIUS_MIN:    r_rad_min <= i_cfg_data;
                CFG_RADIUS_MAX:    r_rad_max <= i_cfg_data;
                CFG_AZIMUTH_MIN:   r_az_min  <= i_cfg_data[16:0];
                CFG_AZIMUTH_MAX:   r_az_max  <= i_cfg_data[16:0];
                CFG_ELEVATION_MIN: r_el_min  <= $signed(i_cfg_data[15:0]);
                CFG_ELEVATION_MAX: r_el_max  <= $signed(i_cfg_data[15:0]);
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_ce) begin
            r_vld <= {r_vld[PIPE_DEPTH-2:0], i_in_valid};
        end
    end

    assign w_mx = r_s1.x_coord[31] ? (~r_s1.x_coord + 32'd1) : r_s1.x_coord;
    assign w_my = r_s1.y_coord[31] ? (~r_s1.y_coord + 32'd1) : r_s1.y_coord;
    assign w_mz = r_s1.z_coord[31] ? (~r_s1.z_coord + 32'd1) : r_s1.z_coord;

    always_comb begin
        n_au = $signed({1'b0, w_mx});
        n_av = r_s1.x_coord[31] ? -33'(r_s1.y_coord) : 33'(r_s1.y_coord);
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_s1   <= i_in_data;
            r_sx   <= 64'(w_mx) * 64'(w_mx);
            r_sy   <= 64'(w_my) * 64'(w_my);
            r_sz   <= 64'(w_mz) * 64'(w_mz);
            r_au   <= n_au;
            r_av   <= n_av;
            r_base <= r_s1.x_coord[31];
            r_z2   <= r_s1.z_coord;
            r_rxy2 <= r_sx + r_sy;
            r_r2   <= r_sx + r_sy + r_sz;
        end
    end

    c2sw_sqrt u_sqrt_rho (
        .i_clk  (i_clk),
        .i_ce   (w_ce),
        .i_val  (r_rxy2),
        .o_root (w_rho)
    );

    c2sw_sqrt u_sqrt_rad (
        .i_clk  (i_clk),
        .i_ce   (w_ce),
        .i_val  (r_r2),
        .o_root (w_rad)
    );

    c2sw_delay #(.W(DA_W), .D(SQRT_STEPS + 1)) u_delay_a (
        .i_clk (i_clk),
        .i_ce  (w_ce),
        .i_d   ({r_au, r_av, r_base, r_z2}),
        .o_q   (w_da)
    );

    assign {w_d_au, w_d_av, w_d_base, w_d_z} = w_da;

    c2sw_cordic u_cordic_az (
        .i_clk   (i_clk),
        .i_ce    (w_ce),
        .i_u     (w_d_au),
        .i_v     (w_d_av),
        .o_angle (w_acc_az)
    );

    c2sw_cordic u_cordic_el (
        .i_clk   (i_clk),
        .i_ce    (w_ce),
        .i_u     ($signed({1'b0, w_rho})),
        .i_v     (33'(w_d_z)),
        .o_angle (w_acc_el)
    );

    c2sw_delay #(.W(DB_W), .D(CORDIC_LAT)) u_delay_b (
        .i_clk (i_clk),
        .i_ce  (w_ce),
        .i_d   ({w_rad, w_d_base, (w_rho == 32'd0), w_d_z[31], (w_d_z != 32'sd0)}),
        .o_q   (w_db)
    );

    assign {w_b_rad, w_b_base, w_b_rho0, w_b_zneg, w_b_znz} = w_db;

    always_comb begin
        w_az_sum = 26'(w_acc_az) + 26'sd128 + (w_b_base ? 26'sd8388608 : 26'sd0);
        w_el_sum = 25'(w_acc_el) + 25'sd128;
        w_el_sh  = w_el_sum >>> 8;
        n_az     = w_b_rho0 ? 16'd0 : w_az_sum[23:8];
        if (w_b_rho0) begin
            if (!w_b_znz) begin
                n_el = 16'sd0;
            end else if (w_b_zneg) begin
                n_el = -16'sd16384;
            end else begin
                n_el = 16'sd16384;
            end
        end else if (w_el_sh > 25'sd16384) begin
            n_el = 16'sd16384;
        end else if (w_el_sh < -25'sd16384) begin
            n_el = -16'sd16384;
        end else begin
            n_el = w_el_sh[15:0];
        end
    end

    always_comb begin
        if (r_p_rad < r_rad_min) begin
            n_code = WIN_RAD_LOW;
        end else if (r_p_rad > r_rad_max) begin
            n_code = WIN_RAD_HI;
        end else if ({1'b0, r_p_az} < r_az_min) begin
            n_code = WIN_AZ_LOW;
        end else if ({1'b0, r_p_az} > r_az_max) begin
            n_code = WIN_AZ_HI;
        end else if (r_p_el < r_el_min) begin
            n_code = WIN_EL_LOW;
        end else if (r_p_el > r_el_max) begin
            n_code = WIN_EL_HI;
        end else begin
            n_code = WIN_INSIDE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_p_rad           <= w_b_rad;
            r_p_az            <= n_az;
            r_p_el            <= n_el;
            r_out.radius      <= r_p_rad;
            r_out.azimuth     <= r_p_az;
            r_out.elevation   <= r_p_el;
            r_out.window_code <= n_code;
        end
    end
endmodule

// File: bench/cartesian_to_spherical_window_unit_test.sv
// Self-checking testbench for the Cartesian to spherical window unit.
`timescale 1ns / 1ps
module cartesian_to_spherical_window_unit_test;
    import c2sw_pkg::*;

    localparam int LATENCY = 60;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    t_point      in_data;
    logic        out_valid;
    logic        out_stall;
    t_result     out_data;
    logic        cfg_we;
    t_cfg_idx    cfg_idx;
    logic [31:0] cfg_data;

    cartesian_to_spherical_window_unit u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_data),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    logic [31:0]        lim_rad_min, lim_rad_max;
    logic [16:0]        lim_az_min, lim_az_max;
    logic signed [15:0] lim_el_min, lim_el_max;

    t_point  point_queue[$];
    t_result expected_results[$];
    int      mismatches;
    int      send_idle_pct;
    int      recv_stall_pct;

    localparam int ATAN_STEP [20] = '{
        2097152, 1238021, 654136, 332050, 166669, 83416, 41718, 20860,
        10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5
    };

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic longint floor_shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bit_val;
        res = 0;
        bit_val = 64'd1 << 62;
        while (bit_val > v) bit_val = bit_val >> 2;
        while (bit_val != 0) begin
            if (v >= res + bit_val) begin
                v = v - (res + bit_val);
                res = (res >> 1) + bit_val;
            end else begin
                res = res >> 1;
            end
            bit_val = bit_val >> 2;
        end
        return res;
    endfunction

    function automatic longint vector_angle(longint u, longint v);
        longint acc, mag, du, dv;
        acc = 0;
        mag = (v < 0) ? -v : v;
        if (u > mag) mag = u;
        if (mag == 0) return 0;
        while (mag < (64'sd1 <<< 31)) begin
            u = u * 2;
            v = v * 2;
            mag = mag * 2;
        end
        for (int i = 0; i < 20; i++) begin
            du = floor_shr(v, i);
            dv = floor_shr(u, i);
            if (v > 0) begin
                u = u + du;
                v = v - dv;
                acc = acc + ATAN_STEP[i];
            end else begin
                u = u - du;
                v = v + dv;
                acc = acc - ATAN_STEP[i];
            end
        end
        return acc;
    endfunction

    function automatic t_result convert_point(t_point p);
        t_result     r;
        longint      x, y, z, rho, el, acc, base;
        logic [63:0] rxy2, rad;
        logic [15:0] az;
        t_win_code   code;
        x = p.x_coord;
        y = p.y_coord;
        z = p.z_coord;
        rxy2 = x * x + y * y;
        rad = int_sqrt(rxy2 + z * z);
        rho = longint'(int_sqrt(rxy2));
        az = 0;
        if (x != 0 || y != 0) begin
            base = 0;
            if (x < 0) begin
                x = -x;
                y = -y;
                base = 64'sd1 <<< 23;
            end
            acc = base + vector_angle(x, y) + 128;
            az = acc[23:8];
        end
        if (rho == 0) begin
            el = (z > 0) ? 16384 : ((z < 0) ? -16384 : 0);
        end else begin
            el = floor_shr(vector_angle(rho, z) + 128, 8);
            if (el > 16384) el = 16384;
            if (el < -16384) el = -16384;
        end
        if (rad < lim_rad_min) code = WIN_RAD_LOW;
        else if (rad > lim_rad_max) code = WIN_RAD_HI;
        else if (az < lim_az_min) code = WIN_AZ_LOW;
        else if (az > lim_az_max) code = WIN_AZ_HI;
        else if (el < lim_el_min) code = WIN_EL_LOW;
        else if (el > lim_el_max) code = WIN_EL_HI;
        else code = WIN_INSIDE;
        r.radius = rad[31:0];
        r.azimuth = az;
        r.elevation = el[15:0];
        r.window_code = code;
        return r;
    endfunction

    // Driver: presents queued points, predicting each one as it is accepted.
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                expected_results.push_back(convert_point(in_data));
                void'(point_queue.pop_front());
            end
            if ((!in_valid || !in_stall) && point_queue.size() > 0) begin
                if ($urandom_range(99) >= send_idle_pct) begin
                    in_valid <= 1'b1;
                    in_data <= point_queue[0];
                end else begin
                    in_valid <= 1'b0;
                end
            end else if (in_valid && !in_stall) begin
                in_valid <= 1'b0;
            end
        end
    end

    // Monitor: compares each result beat against the oldest prediction.
    always @(posedge clk) begin
        t_result want;
        if (rst_n) begin
            out_stall <= ($urandom_range(99) < recv_stall_pct);
            if (out_valid && !out_stall) begin
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result beat %p", out_data);
                end else begin
                    want = expected_results.pop_front();
                    if (out_data !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %p, got %p", want, out_data);
                    end
                end
            end
        end
    end

    task automatic write_reg(t_cfg_idx idx, logic [31:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_RADIUS_MIN:    lim_rad_min = val;
            CFG_RADIUS_MAX:    lim_rad_max = val;
            CFG_AZIMUTH_MIN:   lim_az_min = val[16:0];
            CFG_AZIMUTH_MAX:   lim_az_max = val[16:0];
            CFG_ELEVATION_MIN: lim_el_min = val[15:0];
            CFG_ELEVATION_MAX: lim_el_max = val[15:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        while (point_queue.size() > 0 || in_valid || expected_results.size() > 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    task automatic set_window(logic [31:0] r0, logic [31:0] r1, logic [16:0] a0,
                              logic [16:0] a1, logic [15:0] e0, logic [15:0] e1);
        write_reg(CFG_RADIUS_MIN, r0);
        write_reg(CFG_RADIUS_MAX, r1);
        write_reg(CFG_AZIMUTH_MIN, {15'd0, a0});
        write_reg(CFG_AZIMUTH_MAX, {15'd0, a1});
        write_reg(CFG_ELEVATION_MIN, {16'd0, e0});
        write_reg(CFG_ELEVATION_MAX, {16'd0, e1});
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(3))
            0: return $urandom;
            1: return $signed($urandom_range(2000)) - 1000;
            2: return $signed($urandom_range(32'h00C8_0000)) - 32'sh0064_0000;
            default: return ($urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF)
                            ^ $urandom_range(3);
        endcase
    endfunction

    task automatic add_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        t_point p;
        p.x_coord = x;
        p.y_coord = y;
        p.z_coord = z;
        point_queue.push_back(p);
    endtask

    initial begin
        t_point p;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = CFG_RADIUS_MIN;
        cfg_data = '0;
        mismatches = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        lim_rad_min = 0;
        lim_rad_max = 6553600;
        lim_az_min = 0;
        lim_az_max = 16384;
        lim_el_min = 0;
        lim_el_max = 16384;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        add_point(0, 0, 0);
        add_point(0, 0, 32'h0001_0000);
        add_point(0, 0, 32'hFFFF_0000);
        add_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        add_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        add_point(32'h8000_0000, 0, 0);
        add_point(0, 32'h8000_0000, 0);
        add_point(0, 32'h7FFF_FFFF, 0);
        add_point(32'h0001_0000, 0, 0);
        add_point(32'hFFFF_0000, 0, 0);
        add_point(32'hFFFF_0000, 32'hFFFF_FFFF, 0);
        add_point(32'hFFFF_0000, 32'h0000_0001, 0);
        add_point(1, 0, 32'h7FFF_FFFF);
        add_point(1, 0, 32'h8000_0000);
        add_point(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
        add_point(1, 1, 1);
        add_point(32'h0050_0000, 32'h0030_0000, 32'h0010_0000);
        drain();

        set_window(32'hFFFF_FFFF, 32'd0, 17'd65536, 17'd0, 16'h4000, 16'hC000);
        add_point(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
        add_point(0, 0, 0);
        drain();
        set_window(32'd0, 32'hFFFF_FFFF, 17'd0, 17'd65536, 16'hC000, 16'h4000);
        write_reg(t_cfg_idx'(3'd7), 32'h1234_5678);
        add_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        add_point(5, 0, 0);
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
                default: begin send_idle_pct = 36; recv_stall_pct = 36; end
            endcase
            case (ph)
                0: ;
                1: set_window(32'h0010_0000, 32'h0200_0000, 17'd8000, 17'd40000,
                              16'hE000, 16'h2000);
                2: set_window($urandom, $urandom, 17'($urandom_range(65536)),
                              17'($urandom_range(65536)),
                              16'($signed($urandom_range(32768)) - 16384),
                              16'($signed($urandom_range(32768)) - 16384));
                3: set_window(32'd0, 32'hFFFF_FFFF, 17'd0, 17'd65536, 16'hC000, 16'h4000);
                default: set_window($urandom_range(32'h0100_0000), $urandom,
                              17'($urandom_range(32768)), 17'(32768 + $urandom_range(32768)),
                              16'(-$signed($urandom_range(16384))),
                              16'($urandom_range(16384)));
            endcase
            for (int n = 0; n < 204; n++) begin
                p.x_coord = rand_coord();
                p.y_coord = ($urandom_range(19) == 0) ? 32'd0 : rand_coord();
                p.z_coord = ($urandom_range(9) == 0) ? 32'd0 : rand_coord();
                if ($urandom_range(19) == 0) p.x_coord = 0;
                point_queue.push_back(p);
            end
            drain();
        end

        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("PASS cartesian_to_spherical_window_unit");
        end else begin
            $display("FAIL cartesian_to_spherical_window_unit");
        end
        $finish;
    end

    initial begin
        #(5_000_000);
        $display("FAIL cartesian_to_spherical_window_unit");
        $finish;
    end
endmodule
